// ===== sv/lts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loss-tolerant stop-and-wait sender: shared definitions
// Item, result and configuration types, event and status codes, register
// indexes and fixed field widths.
// ----------------------------------------------------------------------------
package lts_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Scale of the loss percentage compare
  localparam int PCT_SCALE = 100;

  // Event kinds
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_SEND    = 2'd0;
  localparam cmd_t CMD_ACK     = 2'd1;
  localparam cmd_t CMD_TIMEOUT = 2'd2;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_SENT_NEW   = 3'd0;
  localparam status_t ST_DELIVERED  = 3'd1;
  localparam status_t ST_LOSS_OK    = 3'd2;
  localparam status_t ST_RETRANSMIT = 3'd3;
  localparam status_t ST_IGNORED    = 3'd4;
  localparam status_t ST_GAVE_UP    = 3'd5;
  localparam status_t ST_REFUSED    = 3'd6;

  // Configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_LINK_EST     = 3'd0;
  localparam cfg_idx_t REG_LOCAL_PORT   = 3'd1;
  localparam cfg_idx_t REG_REMOTE_PORT  = 3'd2;
  localparam cfg_idx_t REG_MAX_LOSS_PCT = 3'd3;
  localparam cfg_idx_t REG_MAX_ATTEMPTS = 3'd4;

  typedef struct packed {
    logic        link_established;
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [6:0]  max_loss_percent;
    logic [7:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  socket_id;
    logic [15:0] payload_length;
    logic        ack_flag;
    logic        ack_number;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        transmit;
    logic        seq_bit;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] length_out;
    logic [7:0]  attempt_count;
    logic [6:0]  window_losses;
  } result_t;

endpackage

// ===== sv/lts_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loss-tolerant stop-and-wait sender: configuration registers
// Holds the link, port and limit registers and decodes register writes.
// ----------------------------------------------------------------------------
module lts_cfg
  import lts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  cfg_idx_t              wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  // Decode one write transaction into its register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_established <= 1'b0;
      cfg.local_port       <= 16'd0;
      cfg.remote_port      <= 16'd0;
      cfg.max_loss_percent <= 7'd10;
      cfg.max_attempts     <= 8'd20;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LINK_EST:     cfg.link_established <= wr_data[0];
        REG_LOCAL_PORT:   cfg.local_port       <= wr_data[15:0];
        REG_REMOTE_PORT:  cfg.remote_port      <= wr_data[15:0];
        REG_MAX_LOSS_PCT: cfg.max_loss_percent <= wr_data[6:0];
        REG_MAX_ATTEMPTS: cfg.max_attempts     <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/lts_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loss-tolerant stop-and-wait sender: protocol core
// Holds the sequence, attempt and outcome window state and works out the
// result of one event combinationally; state moves when fire is high.
// ----------------------------------------------------------------------------
module lts_core
  import lts_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LOSS_W = $clog2(WINDOW + 1);
  localparam int PROD_W = $clog2(127 * WINDOW + 1);

  // Protocol state
  logic              next_seq, next_seq_next;
  logic              waiting, waiting_next;
  logic [7:0]        attempts, attempts_next;
  logic              pending_seq, pending_seq_next;
  logic [15:0]       pending_length, pending_length_next;
  logic [WINDOW-1:0] window, window_next;
  logic [POS_W-1:0]  position, position_next;
  logic [LOSS_W-1:0] losses, losses_next;

  // Loss test terms
  logic              slot_bit;
  logic [LOSS_W-1:0] losses_marked;
  logic [PROD_W-1:0] loss_scaled;
  logic [PROD_W-1:0] loss_limit;
  logic              loss_ok;
  logic [POS_W-1:0]  position_inc;
  status_t           status;
  logic              tx;

  assign slot_bit      = window[position];
  assign losses_marked = losses + LOSS_W'(slot_bit);
  assign loss_scaled   = PROD_W'(losses_marked) * PROD_W'(PCT_SCALE);
  assign loss_limit    = PROD_W'(cfg.max_loss_percent) * PROD_W'(WINDOW);
  assign loss_ok       = (loss_scaled <= loss_limit);
  assign position_inc  = (position == POS_W'(WINDOW - 1)) ? '0 : position + 1'b1;

  // Decide the event outcome and the next state
  always_comb begin
    next_seq_next       = next_seq;
    waiting_next        = waiting;
    attempts_next       = attempts;
    pending_seq_next    = pending_seq;
    pending_length_next = pending_length;
    window_next         = window;
    position_next       = position;
    losses_next         = losses;
    status              = ST_IGNORED;
    tx                  = 1'b0;
    case (item.cmd)
      CMD_SEND: begin
        if (item.socket_id != 8'd0 || !cfg.link_established || waiting) begin
          status = ST_REFUSED;
        end else begin
          pending_seq_next    = next_seq;
          pending_length_next = item.payload_length;
          next_seq_next       = ~next_seq;
          attempts_next       = 8'd1;
          waiting_next        = 1'b1;
          status              = ST_SENT_NEW;
          tx                  = 1'b1;
        end
      end
      CMD_ACK: begin
        if (waiting && item.ack_flag && item.ack_number == next_seq) begin
          window_next[position] = 1'b1;
          losses_next           = losses - LOSS_W'(!slot_bit);
          position_next         = position_inc;
          waiting_next          = 1'b0;
          status                = ST_DELIVERED;
        end
      end
      CMD_TIMEOUT: begin
        if (waiting) begin
          window_next[position] = 1'b0;
          losses_next           = losses_marked;
          if (loss_ok) begin
            next_seq_next = ~next_seq;
            position_next = position_inc;
            waiting_next  = 1'b0;
            status        = ST_LOSS_OK;
          end else if (attempts < cfg.max_attempts) begin
            attempts_next = attempts + 8'd1;
            status        = ST_RETRANSMIT;
            tx            = 1'b1;
          end else begin
            waiting_next = 1'b0;
            status       = ST_GAVE_UP;
          end
        end
      end
      default: ;
    endcase
  end

  // Build the result; header fields are zero when nothing goes out
  always_comb begin
    result.status        = status;
    result.transmit      = tx;
    result.seq_bit       = tx ? pending_seq_next : 1'b0;
    result.src_port      = tx ? cfg.local_port : 16'd0;
    result.dst_port      = tx ? cfg.remote_port : 16'd0;
    result.length_out    = tx ? pending_length_next : 16'd0;
    result.attempt_count = attempts_next;
    result.window_losses = 7'(losses_next);
  end

  // Advance state on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      next_seq       <= 1'b0;
      waiting        <= 1'b0;
      attempts       <= 8'd0;
      pending_seq    <= 1'b0;
      pending_length <= 16'd0;
      window         <= '1;
      position       <= '0;
      losses         <= '0;
    end else if (fire) begin
      next_seq       <= next_seq_next;
      waiting        <= waiting_next;
      attempts       <= attempts_next;
      pending_seq    <= pending_seq_next;
      pending_length <= pending_length_next;
      window         <= window_next;
      position       <= position_next;
      losses         <= losses_next;
    end
  end

endmodule

// ===== sv/loss_tolerant_stop_and_wait_sender_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Loss-tolerant stop-and-wait sender
// Sender half of an alternating-bit link that may accept lost PDUs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one event: send, ack arrived
//   or ack timer expired. Output channel (out_valid / out_stall) returns one
//   result per event: status, the PDU header when one goes out, the attempt
//   count and the losses in the outcome window.
//   Configuration writes use cfg_valid / cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write only while the block is idle.
//   An accepted event reaches the output through the input register, then
//   the result register. Throughput: one event per cycle while the output
//   is not stalled; the loss counter is updated incrementally so each event
//   settles in one pass through the core between the two registers.
//   A stalled output holds its result; one more event can wait in the input
//   register, after which in_stall rises until the output drains.
//   Reset (rst, synchronous) empties both registers, restores the default
//   limits and marks every window slot as a success.
// ----------------------------------------------------------------------------
module loss_tolerant_stop_and_wait_sender_unit
  import lts_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  // Event channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            cmd,
  input  logic [7:0]            socket_id,
  input  logic [15:0]           payload_length,
  input  logic                  ack_flag,
  input  logic                  ack_number,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic                  transmit,
  output logic                  seq_bit,
  output logic [15:0]           src_port,
  output logic [15:0]           dst_port,
  output logic [15:0]           length_out,
  output logic [7:0]            attempt_count,
  output logic [6:0]            window_losses,
  // Configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item_reg;
  logic    item_valid;
  result_t core_result;
  result_t result_reg;
  logic    in_accept;
  logic    advance;

  assign cfg_ready = 1'b1;

  lts_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Move the held event into the result register unless that is blocked
  assign advance   = item_valid && !(out_valid && out_stall);
  assign in_stall  = item_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Hold the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_reg.cmd            <= cmd;
      item_reg.socket_id      <= socket_id;
      item_reg.payload_length <= payload_length;
      item_reg.ack_flag       <= ack_flag;
      item_reg.ack_number     <= ack_number;
    end
  end

  lts_core #(
    .WINDOW (WINDOW)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item_reg),
    .cfg    (cfg),
    .result (core_result)
  );

  // Register the result and hold it while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= core_result;
    end
  end

  assign status        = result_reg.status;
  assign transmit      = result_reg.transmit;
  assign seq_bit       = result_reg.seq_bit;
  assign src_port      = result_reg.src_port;
  assign dst_port      = result_reg.dst_port;
  assign length_out    = result_reg.length_out;
  assign attempt_count = result_reg.attempt_count;
  assign window_losses = result_reg.window_losses;

`ifndef SYNTHESIS
  // Input holds off only behind a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A header goes out exactly for a new send or a retransmission
  a_tx_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (transmit == (status == ST_SENT_NEW || status == ST_RETRANSMIT)))
    else $error("transmit flag disagrees with status");

  // Losses never exceed the window size
  a_loss_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_losses <= 7'(WINDOW)))
    else $error("window loss count out of range");

  // A held event reaches the output in the next cycle when not blocked
  a_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed event did not reach the result register");
`endif

endmodule
